>>> design/assert_macros.svh
// Assertion macros shared by the iterated MD5 hash block.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock, disabled while reset is active.
`define IMPH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that must hold at every edge, reset included.
`define IMPH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/imph_pkg.sv
// Package for the iterated MD5 password hash: payload types, MD5 constants,
// and small helper functions. No dependencies.
package imph_pkg;

  localparam int SALT_LEN     = 8;
  localparam int DIGEST_BYTES = 16;
  localparam int HASH_CHARS   = 22;
  localparam int PLEN_W       = 8;   // holds any password length up to 255
  localparam int LEN_W        = 10;  // message length and global byte index
  localparam int BLK_W        = LEN_W - 6;
  localparam int CNT_W        = 5;
  localparam int MAX_LOG2     = 30;

  localparam logic OP_SALT = 1'b0;
  localparam logic OP_PASS = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Chaining words packed with word 0 in the low bits.
  localparam logic [127:0] MD5_IV =
    {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } imph_in_t;

  typedef struct packed {
    logic [7:0] hash_char;
    logic       last_char;
    logic       overflow;
  } imph_out_t;

  // One hash job handed from the front to the back.
  typedef struct packed {
    logic [3:0]        salt_len;
    logic [PLEN_W-1:0] pw_len;
    logic              overflow;
  } imph_job_t;

  // Status from the back: the stores are being read.
  typedef struct packed {
    logic busy;
  } imph_stat_t;

  // Byte write into the MD5 block buffer.
  typedef struct packed {
    logic       wr_en;
    logic [5:0] addr;
    logic [7:0] data;
  } imph_fill_t;

  // Rotate amount of one MD5 round.
  function automatic logic [4:0] md5_shift(input logic [5:0] i);
    return MD5_S[{i[5:4], i[1:0]}];
  endfunction

  // Message word used by one MD5 round.
  function automatic logic [3:0] md5_word(input logic [5:0] i);
    logic [7:0] t;
    unique case (i[5:4])
      2'd0:    t = {4'b0000, i[3:0]};
      2'd1:    t = 8'(5 * i + 1);
      2'd2:    t = 8'(3 * i + 5);
      default: t = 8'(7 * i);
    endcase
    return t[3:0];
  endfunction

  // Six-bit value to the "./0-9A-Za-z" alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd2)       return 8'(w + 8'd46);
    else if (v < 6'd12) return 8'(w + 8'd46);
    else if (v < 6'd38) return 8'(w + 8'd53);
    else                return 8'(w + 8'd59);
  endfunction

endpackage

>>> design/imph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/imph_front.sv
// Front end: accepts salt and password bytes, keeps the salt and counts, and
// queues one hash job for the back end. Uses imph_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imph_front import imph_pkg::*; #(
  parameter int MAX_PASSWORD = 64,
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  imph_in_t      in_data_i,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [7:0]    ram_wdata_o,
  output logic [63:0]   salt_o,
  output logic          job_valid_o,
  output imph_job_t     job_o,
  input  logic          job_ready_i,
  input  imph_stat_t    stat_i
);

  logic [63:0]       salt_q;
  logic [3:0]        salt_cnt_q;
  logic [PLEN_W-1:0] pw_len_q;
  logic              ovf_q;
  logic              job_valid_q;
  imph_job_t         job_q;

  logic acc, pw_room, salt_room, push;
  logic [PLEN_W-1:0] pw_len_nx;
  logic              ovf_nx;

  // Hold off input while a job waits or the stores are being read.
  assign in_ready_o = !job_valid_q && !stat_i.busy;
  assign acc        = in_valid_i && in_ready_o;
  assign pw_room    = pw_len_q < PLEN_W'(MAX_PASSWORD);
  assign salt_room  = salt_cnt_q < 4'(SALT_LEN);
  assign push       = acc && (in_data_i.op == OP_PASS) && in_data_i.last;
  assign pw_len_nx  = pw_room ? PLEN_W'(pw_len_q + 1'b1) : pw_len_q;
  assign ovf_nx     = ovf_q || !pw_room;

  // Password bytes go straight to the store.
  assign ram_we_o    = acc && (in_data_i.op == OP_PASS) && pw_room;
  assign ram_waddr_o = pw_len_q[AW-1:0];
  assign ram_wdata_o = in_data_i.data_byte;
  assign salt_o      = salt_q;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  // Salt bytes.
  always_ff @(posedge clk_i) begin
    if (acc && (in_data_i.op == OP_SALT) && salt_room) begin
      salt_q[{salt_cnt_q[2:0], 3'b000} +: 8] <= in_data_i.data_byte;
    end
  end

  // Counters and the one-entry job queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_cnt_q  <= '0;
      pw_len_q    <= '0;
      ovf_q       <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      if (job_valid_q && job_ready_i) begin
        job_valid_q <= 1'b0;
      end
      if (push) begin
        salt_cnt_q  <= '0;
        pw_len_q    <= '0;
        ovf_q       <= 1'b0;
        job_valid_q <= 1'b1;
      end else if (acc && (in_data_i.op == OP_SALT)) begin
        if (salt_room) begin
          salt_cnt_q <= 4'(salt_cnt_q + 1'b1);
        end
      end else if (acc) begin
        pw_len_q <= pw_len_nx;
        ovf_q    <= ovf_nx;
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      job_q.salt_len <= salt_cnt_q;
      job_q.pw_len   <= pw_len_nx;
      job_q.overflow <= ovf_nx;
    end
  end

  // A queued job holds until the back end takes it.
  `IMPH_ASSERT(a_job_hold, clk_i, rst_ni,
               job_valid_q && !job_ready_i |=> job_valid_q && $stable(job_q),
               "queued job changed before it was taken")

endmodule

>>> design/imph_md5.sv
// MD5 compression unit: 64-byte block buffer and one round per cycle.
// Uses imph_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imph_md5 import imph_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  imph_fill_t   fill_i,
  input  logic         start_i,
  input  logic [127:0] chain_i,
  output logic         done_o,
  output logic [127:0] chain_o
);

  logic [31:0]  blk_q [16];
  logic [31:0]  a_q, b_q, c_q, d_q, km_q;
  logic [5:0]   i_q;
  logic         run_q, fin_q, done_q;
  logic [127:0] res_q;

  logic [5:0]  idx_nx;
  logic [31:0] km_nx, f, sum, rot;
  logic [63:0] dbl;

  // Block buffer, written one byte at a time.
  always_ff @(posedge clk_i) begin
    if (fill_i.wr_en) begin
      blk_q[fill_i.addr[5:2]][{fill_i.addr[1:0], 3'b000} +: 8] <= fill_i.data;
    end
  end

  // Constant plus message word for the next round, registered the cycle before it is used.
  assign idx_nx = start_i ? 6'd0 : 6'(i_q + 1'b1);
  assign km_nx  = MD5_K[idx_nx] + blk_q[md5_word(idx_nx)];

  // Round function.
  always_comb begin
    unique case (i_q[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign sum = a_q + f + km_q;
  assign dbl = {sum, sum} << md5_shift(i_q);
  assign rot = dbl[63:32];

  // Round control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      fin_q  <= 1'b0;
      done_q <= fin_q;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= 6'(i_q + 1'b1);
        if (i_q == 6'd63) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  // Working variables and the final feed-forward add.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= chain_i[31:0];
      b_q  <= chain_i[63:32];
      c_q  <= chain_i[95:64];
      d_q  <= chain_i[127:96];
      km_q <= km_nx;
    end else if (run_q) begin
      a_q  <= d_q;
      d_q  <= c_q;
      c_q  <= b_q;
      b_q  <= b_q + rot;
      km_q <= km_nx;
    end
    if (fin_q) begin
      res_q <= {d_q + chain_i[127:96], c_q + chain_i[95:64],
                b_q + chain_i[63:32], a_q + chain_i[31:0]};
    end
  end

  assign done_o  = done_q;
  assign chain_o = res_q;

  // A block never starts while another is being compressed.
  `IMPH_ASSERT(a_no_restart, clk_i, rst_ni, start_i |-> !run_q && !fin_q,
               "block started during compression")

endmodule

>>> design/imph_back.sv
// Back end: builds padded MD5 blocks from salt, digest and password, runs the
// iterated rounds, and emits the encoded hash. Uses imph_pkg, assert_macros.svh.
`include "assert_macros.svh"

module imph_back import imph_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [4:0]    log2_rounds_i,
  input  logic          job_valid_i,
  input  imph_job_t     job_i,
  output logic          job_ready_o,
  input  logic [63:0]   salt_i,
  output logic [AW-1:0] ram_raddr_o,
  input  logic [7:0]    ram_rdata_i,
  output imph_stat_t    stat_o,
  output imph_fill_t    fill_o,
  output logic          core_start_o,
  output logic [127:0]  core_chain_o,
  input  logic          core_done_i,
  input  logic [127:0]  core_chain_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output imph_out_t     out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [5:0]        pos_q, pos_d;
  logic              first_q, first_d;
  logic [30:0]       rounds_q, rounds_d;
  logic [3:0]        salt_len_q, salt_len_d;
  logic [PLEN_W-1:0] pw_len_q, pw_len_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [127:0]      chain_q, chain_d;
  logic [127:0]      digest_q, digest_d;
  logic              wr_valid_q, wr_valid_d;
  logic [5:0]        wr_pos_q;
  logic              wr_ram_q, sel_ram;
  logic [7:0]        wr_byte_q, sel_byte;
  logic              out_valid_q, out_valid_d;
  imph_out_t         out_q, out_d;

  logic [LEN_W-1:0] prefix_len, msg_len, padded, gi, pw_idx;
  logic [BLK_W-1:0] nblk;
  logic             last_blk, out_load;
  logic [12:0]      bitlen;
  logic [4:0]       n_clamped;

  // Message layout of the current pass.
  assign prefix_len = first_q ? LEN_W'(salt_len_q) : LEN_W'(DIGEST_BYTES);
  assign msg_len    = LEN_W'(prefix_len + LEN_W'(pw_len_q));
  assign padded     = LEN_W'(msg_len + LEN_W'(72));
  assign nblk       = padded[LEN_W-1:6];
  assign last_blk   = BLK_W'(blk_q + 1'b1) == nblk;
  assign gi         = {blk_q, pos_q};
  assign pw_idx     = LEN_W'(gi - prefix_len);
  assign bitlen     = {msg_len, 3'b000};
  assign ram_raddr_o = pw_idx[AW-1:0];
  assign n_clamped  = (log2_rounds_i > 5'(MAX_LOG2)) ? 5'(MAX_LOG2) : log2_rounds_i;

  // Source of the byte at the current fill position.
  always_comb begin
    sel_ram  = 1'b0;
    sel_byte = 8'h00;
    priority if (gi < prefix_len) begin
      sel_byte = first_q ? salt_i[{gi[2:0], 3'b000} +: 8]
                         : digest_q[{gi[3:0], 3'b000} +: 8];
    end else if (gi < msg_len) begin
      sel_ram = 1'b1;
    end else if (gi == msg_len) begin
      sel_byte = PAD_BYTE;
    end else if (last_blk && pos_q == 6'd56) begin
      sel_byte = bitlen[7:0];
    end else if (last_blk && pos_q == 6'd57) begin
      sel_byte = {3'b000, bitlen[12:8]};
    end else begin
      sel_byte = 8'h00;
    end
  end

  // Block buffer writes, registered in the cycle after the store read.
  assign fill_o.wr_en = wr_valid_q;
  assign fill_o.addr  = wr_pos_q;
  assign fill_o.data  = wr_ram_q ? ram_rdata_i : wr_byte_q;

  assign core_start_o = (state_q == S_DRAIN);
  assign core_chain_o = chain_q;
  assign job_ready_o  = (state_q == S_IDLE);
  assign stat_o.busy  = (state_q == S_FILL) || (state_q == S_DRAIN) || (state_q == S_RUN);

  assign out_load = (state_q == S_OUT) && (cnt_q < CNT_W'(HASH_CHARS)) &&
                    (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    blk_d      = blk_q;
    pos_d      = pos_q;
    first_d    = first_q;
    rounds_d   = rounds_q;
    salt_len_d = salt_len_q;
    pw_len_d   = pw_len_q;
    ovf_d      = ovf_q;
    cnt_d      = cnt_q;
    chain_d    = chain_q;
    digest_d   = digest_q;
    wr_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          salt_len_d = job_i.salt_len;
          pw_len_d   = job_i.pw_len;
          ovf_d      = job_i.overflow;
          rounds_d   = 31'(1) << n_clamped;
          first_d    = 1'b1;
          chain_d    = MD5_IV;
          blk_d      = '0;
          pos_d      = '0;
          cnt_d      = '0;
          state_d    = S_FILL;
        end
      end
      S_FILL: begin
        wr_valid_d = 1'b1;
        pos_d      = 6'(pos_q + 1'b1);
        if (pos_q == 6'd63) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        if (core_done_i) begin
          pos_d = '0;
          if (!last_blk) begin
            blk_d   = BLK_W'(blk_q + 1'b1);
            chain_d = core_chain_i;
            state_d = S_FILL;
          end else begin
            digest_d = core_chain_i;
            chain_d  = MD5_IV;
            blk_d    = '0;
            state_d  = S_FILL;
            if (first_q) begin
              first_d = 1'b0;
            end else if (rounds_q == 31'd1) begin
              state_d = S_OUT;
            end else begin
              rounds_d = 31'(rounds_q - 1'b1);
            end
          end
        end
      end
      S_OUT: begin
        if (cnt_q == CNT_W'(HASH_CHARS)) begin
          state_d = S_IDLE;
        end else if (out_load) begin
          digest_d = digest_q >> 6;
          cnt_d    = CNT_W'(cnt_q + 1'b1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: a new character loads when the slot is free.
  always_comb begin
    out_d           = out_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d     = 1'b1;
      out_d.hash_char = b64_char(digest_q[5:0]);
      out_d.last_char = (cnt_q == CNT_W'(HASH_CHARS - 1));
      out_d.overflow  = ovf_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blk_q       <= '0;
      pos_q       <= '0;
      first_q     <= 1'b0;
      cnt_q       <= '0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_q       <= blk_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      wr_valid_q  <= wr_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rounds_q   <= rounds_d;
    salt_len_q <= salt_len_d;
    pw_len_q   <= pw_len_d;
    ovf_q      <= ovf_d;
    chain_q    <= chain_d;
    digest_q   <= digest_d;
    out_q      <= out_d;
    wr_pos_q   <= pos_q;
    wr_ram_q   <= sel_ram;
    wr_byte_q  <= sel_byte;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Buffer writes only happen while a block is being filled.
  `IMPH_ASSERT(a_fill_window, clk_i, rst_ni,
               wr_valid_q |-> state_q == S_FILL || state_q == S_DRAIN,
               "block buffer written outside the fill phase")
  // Never more characters than one hash has.
  `IMPH_ASSERT_ALWAYS(a_char_count, clk_i, cnt_q <= CNT_W'(HASH_CHARS),
                      "character count out of range")

endmodule

>>> design/iterated_md5_password_hash.sv
// Channel | Direction | Payload
// --------+-----------+--------------------------------------------
// cfg     | in        | log2_rounds, 5 bits
// in      | in        | imph_in_t: op, data_byte, last
// out     | out       | imph_out_t: hash_char, last_char, overflow
//
// Salt and password bytes are taken one per cycle while in_ready_o is high.
// The final password byte starts a hash of 2^n + 1 MD5 passes (n =
// log2_rounds, at most 30); each 64-byte block is filled from the stores
// and then run through the one-round-per-cycle compression unit; a pass has
// one or two blocks. The 22 characters then leave at one per cycle when
// out_ready_i is high. Input is held off while a job waits or the stores are
// being read. Reset clears control state only; no clearing pass is needed.
// Top level of the iterated MD5 password hash; uses imph_pkg, imph_front,
// imph_back, imph_md5 and imph_ram.
module iterated_md5_password_hash import imph_pkg::*; #(
  parameter int MAX_PASSWORD = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  imph_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output imph_out_t  out_data_o
);

  localparam int PW_AW = (MAX_PASSWORD > 1) ? $clog2(MAX_PASSWORD) : 1;

  logic [4:0]       log2_rounds_q;
  logic             ram_we;
  logic [PW_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [63:0]      salt;
  logic             job_valid, job_ready;
  imph_job_t        job;
  imph_stat_t       stat;
  imph_fill_t       fill;
  logic             core_start, core_done;
  logic [127:0]     core_chain_in, core_chain_out;

  // Rounds register; a transfer is always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_rounds_q <= 5'd10;
    end else if (cfg_valid_i) begin
      log2_rounds_q <= cfg_data_i;
    end
  end

  imph_front #(.MAX_PASSWORD(MAX_PASSWORD), .AW(PW_AW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .ram_we_o(ram_we), .ram_waddr_o(ram_waddr), .ram_wdata_o(ram_wdata),
    .salt_o(salt), .job_valid_o(job_valid), .job_o(job),
    .job_ready_i(job_ready), .stat_i(stat)
  );

  imph_ram #(.WIDTH(8), .DEPTH(MAX_PASSWORD)) u_pw_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  imph_back #(.AW(PW_AW)) u_back (
    .clk_i, .rst_ni, .log2_rounds_i(log2_rounds_q),
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .salt_i(salt), .ram_raddr_o(ram_raddr), .ram_rdata_i(ram_rdata),
    .stat_o(stat), .fill_o(fill), .core_start_o(core_start),
    .core_chain_o(core_chain_in), .core_done_i(core_done),
    .core_chain_i(core_chain_out), .out_valid_o, .out_ready_i, .out_data_o
  );

  imph_md5 u_md5 (
    .clk_i, .rst_ni, .fill_i(fill), .start_i(core_start),
    .chain_i(core_chain_in), .done_o(core_done), .chain_o(core_chain_out)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for iterated_md5_password_hash.
// Depends on imph_pkg and the block's RTL. Hash outputs are checked
// against an in-bench iterated MD5 predictor.
`timescale 1ns / 1ps

module tb;
  import imph_pkg::*;

  localparam int    MAX_PW     = 64;
  localparam int    CYCLE_CAP  = 3000000;
  localparam int    RAND_ITEMS = 290;
  localparam int    SHOW_MAX   = 10;
  localparam string ALPHA =
    "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  imph_in_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  imph_out_t  out_data_o;

  iterated_md5_password_hash #(.MAX_PASSWORD(MAX_PW)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state, updated on every accepted input transfer.
  logic [7:0] salt_q [SALT_LEN];
  int         salt_cnt;
  logic [7:0] pw_q [MAX_PW];
  int         pw_len;
  logic       pw_dropped;
  int         rounds_reg;

  imph_out_t  expected_chars [$];
  int         fail_cnt;
  int         cycle_cnt;
  bit         in_burst;
  bit         out_burst;
  int         out_stall;

  // One MD5 compression of the 64 bytes at base.
  function automatic logic [127:0] md5_compress(input logic [127:0] h,
                                                input logic [7:0] p [$],
                                                input int base);
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, sum, t;
    int          g;
    int          sh;
    for (int w = 0; w < 16; w++)
      m[w] = {p[base+4*w+3], p[base+4*w+2], p[base+4*w+1], p[base+4*w]};
    a = h[31:0];
    b = h[63:32];
    c = h[95:64];
    d = h[127:96];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      sh  = MD5_S[(i / 16) * 4 + i % 4];
      sum = a + f + MD5_K[i] + m[g];
      t   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << sh) | (sum >> (32 - sh)));
      a   = t;
    end
    return {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};
  endfunction

  // Full MD5 with padding; digest byte i sits at bits [8i+7:8i].
  function automatic logic [127:0] md5_of(input logic [7:0] msg [$]);
    logic [7:0]   pad_q [$];
    logic [63:0]  bit_len;
    logic [127:0] h;
    pad_q   = msg;
    bit_len = 64'(msg.size()) * 8;
    pad_q.push_back(PAD_BYTE);
    while (pad_q.size() % 64 != 56) pad_q.push_back(8'h00);
    for (int i = 0; i < 8; i++) pad_q.push_back(bit_len[8*i +: 8]);
    h = MD5_IV;
    for (int blk = 0; blk < pad_q.size(); blk += 64) h = md5_compress(h, pad_q, blk);
    return h;
  endfunction

  // Iterated hash of the stored salt and password, queued as 22 characters.
  function automatic void predict_hash();
    logic [7:0]   msg [$];
    logic [127:0] dg;
    logic [131:0] bits;
    int           n;
    imph_out_t    ch;
    n = (rounds_reg > MAX_LOG2) ? MAX_LOG2 : rounds_reg;
    for (int i = 0; i < salt_cnt; i++) msg.push_back(salt_q[i]);
    for (int i = 0; i < pw_len; i++) msg.push_back(pw_q[i]);
    dg = md5_of(msg);
    for (longint r = 0; r < (longint'(1) << n); r++) begin
      msg.delete();
      for (int i = 0; i < DIGEST_BYTES; i++) msg.push_back(dg[8*i +: 8]);
      for (int i = 0; i < pw_len; i++) msg.push_back(pw_q[i]);
      dg = md5_of(msg);
    end
    // Little-endian bit stream cut into six-bit groups.
    bits = {4'b0000, dg};
    for (int k = 0; k < HASH_CHARS; k++) begin
      ch.hash_char = ALPHA[bits[6*k +: 6]];
      ch.last_char = (k == HASH_CHARS - 1);
      ch.overflow  = pw_dropped;
      expected_chars.push_back(ch);
    end
    salt_cnt   = 0;
    pw_len     = 0;
    pw_dropped = 1'b0;
  endfunction

  // Take one accepted byte into the predictor.
  function automatic void absorb_byte(input imph_in_t it);
    if (it.op == OP_SALT) begin
      if (salt_cnt < SALT_LEN) begin
        salt_q[salt_cnt] = it.data_byte;
        salt_cnt++;
      end
      return;
    end
    if (pw_len < MAX_PW) begin
      pw_q[pw_len] = it.data_byte;
      pw_len++;
    end else begin
      pw_dropped = 1'b1;
    end
    if (it.last) predict_hash();
  endfunction

  // Gap before a transfer: runs of back-to-back traffic mixed with random waits.
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 9) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // Input monitor feeds the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) absorb_byte(in_data_i);
  end

  // Output side: random stalls and the character check.
  always @(posedge clk_i) begin
    imph_out_t exp_ch;
    logic      rdy_nxt;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_MAX)
          $display("unexpected character transfer: %h", out_data_o);
      end else begin
        exp_ch = expected_chars.pop_front();
        if (out_data_o.hash_char !== exp_ch.hash_char ||
            out_data_o.last_char !== exp_ch.last_char ||
            out_data_o.overflow  !== exp_ch.overflow) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_MAX)
            $display("char mismatch: exp char=%h last=%b ovf=%b, got char=%h last=%b ovf=%b",
                     exp_ch.hash_char, exp_ch.last_char, exp_ch.overflow,
                     out_data_o.hash_char, out_data_o.last_char, out_data_o.overflow);
        end
      end
      out_stall = draw_gap(out_burst);
    end
    if (out_stall > 0) begin
      out_stall--;
      rdy_nxt = 1'b0;
    end else begin
      rdy_nxt = 1'b1;
    end
    out_ready_i <= rdy_nxt;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("iterated_md5_password_hash regression: fail");
      $finish;
    end
  end

  // Send one byte; valid stays high across back-to-back transfers.
  task automatic send_byte(input logic op, input logic [7:0] data, input logic last);
    int       gap;
    imph_in_t it;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.op        = op;
    it.data_byte = data;
    it.last      = last;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait for all characters, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_rounds(input logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rounds_reg = v;
  endtask

  // One hash: salt bytes then password; returns the number of bytes sent.
  task automatic send_password(input int n_salt, input int n_pw, output int sent);
    for (int i = 0; i < n_salt; i++)
      send_byte(OP_SALT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < n_pw; i++)
      send_byte(OP_PASS, 8'($urandom_range(0, 255)), i == n_pw - 1);
    sent = n_salt + n_pw;
  endtask

  typedef struct {
    int         set_rounds;   // -1 keeps the current setting
    logic       op;
    logic [7:0] data;
    logic       last;
  } dir_row_t;

  // Directed bytes: edge values, last on salt, extra salt, zero bytes,
  // empty and short salts.
  dir_row_t dir_tab [] = '{
    '{-1, OP_SALT, 8'h00, 1'b1}, '{-1, OP_SALT, 8'hff, 1'b0},
    '{-1, OP_SALT, 8'h55, 1'b0}, '{-1, OP_SALT, 8'haa, 1'b0},
    '{-1, OP_SALT, 8'h01, 1'b0}, '{-1, OP_SALT, 8'h80, 1'b0},
    '{-1, OP_SALT, 8'h7f, 1'b0}, '{-1, OP_SALT, 8'hfe, 1'b0},
    '{-1, OP_SALT, 8'h33, 1'b0}, '{-1, OP_PASS, 8'h00, 1'b0},
    '{-1, OP_PASS, 8'hff, 1'b0}, '{-1, OP_PASS, 8'h80, 1'b1},
    '{ 0, OP_PASS, 8'h00, 1'b1},
    '{ 1, OP_SALT, 8'h24, 1'b0}, '{-1, OP_SALT, 8'h50, 1'b0},
    '{-1, OP_SALT, 8'h00, 1'b0}, '{-1, OP_PASS, 8'h41, 1'b1}
  };

  int rounds_plan [] = '{0, 1, 2, 3, 2};

  initial begin
    int sent;
    int n_salt;
    int n_pw;
    int total;
    int quota;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    salt_cnt   = 0;
    pw_len     = 0;
    pw_dropped = 1'b0;
    rounds_reg = 10;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    out_stall  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part; the first hash runs at the reset setting.
    foreach (dir_tab[r]) begin
      if (dir_tab[r].set_rounds >= 0) begin
        drain();
        write_rounds(5'(dir_tab[r].set_rounds));
      end
      send_byte(dir_tab[r].op, dir_tab[r].data, dir_tab[r].last);
    end
    drain();

    // Random part, one phase per rounds setting.
    total = 0;
    quota = RAND_ITEMS / rounds_plan.size();
    foreach (rounds_plan[p]) begin
      write_rounds(5'(rounds_plan[p]));
      sent = 0;
      // First sequence of the run overflows the password store.
      if (p == 0) begin
        send_password(SALT_LEN, $urandom_range(MAX_PW + 1, MAX_PW + 8), n_pw);
        sent += n_pw;
      end
      while (sent < quota) begin
        n_salt = ($urandom_range(0, 3) != 0) ? SALT_LEN : $urandom_range(0, 10);
        case ($urandom_range(0, 19))
          0:       n_pw = $urandom_range(MAX_PW + 1, MAX_PW + 8);
          1, 2:    n_pw = $urandom_range(25, MAX_PW);
          default: n_pw = $urandom_range(1, 24);
        endcase
        send_password(n_salt, n_pw, n_pw);
        sent += n_pw;
      end
      total += sent;
      drain();
    end

    // Upper end of the register, including a value past the clamp.
    write_rounds(5'd31);
    @(posedge clk_i);
    write_rounds(5'(MAX_LOG2));
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0 && expected_chars.size() == 0) begin
      $display("iterated_md5_password_hash regression: pass");
    end else begin
      $display("iterated_md5_password_hash regression: fail");
    end
    $finish;
  end

endmodule
